/* sv/cisp_pkg.sv */
// shared types and constants of the image stream parser
`default_nettype none

package cisp_pkg;

    // fixed header layout
    localparam int FIXED_HEADER_END = 36;
    localparam int MAGIC_LAST_POS   = 3;
    localparam int FIELD_BITS       = 64;
    localparam int OUT_COORD_BITS   = 16;

    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_NUL     = 8'h00;

    // result kind codes
    typedef enum logic [3:0] {
        KIND_NONE         = 4'd0,
        KIND_MAGIC        = 4'd1,
        KIND_HEADER_SIZE  = 4'd2,
        KIND_CONTENT_SIZE = 4'd3,
        KIND_WIDTH        = 4'd4,
        KIND_HEIGHT       = 4'd5,
        KIND_CAPTION      = 4'd6,
        KIND_TAG          = 4'd7,
        KIND_PIXEL        = 4'd8
    } kind_t;

    // parse phase
    typedef enum logic [1:0] {
        PH_FIXED   = 2'd0,
        PH_CAPTION = 2'd1,
        PH_TAGS    = 2'd2,
        PH_CONTENT = 2'd3
    } phase_t;

    // one input word
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_word_t;

    // one result word
    typedef struct packed {
        kind_t                     kind;
        logic [FIELD_BITS-1:0]     field_value;
        logic [7:0]                red;
        logic [7:0]                green;
        logic [7:0]                blue;
        logic [OUT_COORD_BITS-1:0] pix_row;
        logic [OUT_COORD_BITS-1:0] pixel_col;
        logic                      piece_end;
        logic                      file_end;
    } result_t;

endpackage

`default_nettype wire

/* sv/cisp_in_reg.sv */
// input register stage with valid/stall handshake
`default_nettype none

module cisp_in_reg
    import cisp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire in_word_t in_word,
    input  wire logic     down_ready,
    output logic          advance,
    output in_word_t      held_word
);

    logic     valid_reg;
    logic     valid_next;
    in_word_t word_reg;
    logic     accept;

    // handshake
    assign advance  = valid_reg && down_ready;
    assign in_stall = valid_reg && !down_ready;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload holds while stalled
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg <= in_word;
        end
    end

    assign held_word = word_reg;

endmodule

`default_nettype wire

/* sv/cisp_core.sv */
// parser state and per-byte decode logic
`default_nettype none

module cisp_core
    import cisp_pkg::*;
#(
    parameter int POSITION_BITS = 32,
    parameter int COORD_BITS    = 16
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     fire,
    input  wire in_word_t word,
    output result_t       result
);

    logic [POSITION_BITS-1:0] pos_reg;
    logic [POSITION_BITS-1:0] pos_next;
    logic [FIELD_BITS-1:0]    shifter_reg;
    logic [FIELD_BITS-1:0]    shifter_next;
    logic [FIELD_BITS-1:0]    hdr_len_reg;
    logic [FIELD_BITS-1:0]    hdr_len_next;
    logic [FIELD_BITS-1:0]    frame_width_reg;
    logic [FIELD_BITS-1:0]    frame_width_next;
    phase_t                   phase_reg;
    phase_t                   phase_next;
    logic [1:0]               pix_cnt_reg;
    logic [1:0]               pix_cnt_next;
    logic [7:0]               red_reg;
    logic [7:0]               red_next;
    logic [7:0]               green_reg;
    logic [7:0]               green_next;
    logic [COORD_BITS-1:0]    row_reg;
    logic [COORD_BITS-1:0]    row_next;
    logic [COORD_BITS-1:0]    col_reg;
    logic [COORD_BITS-1:0]    col_next;

    logic [7:0]            b;
    logic                  in_fixed;
    logic [5:0]            pos_lo;
    logic [5:0]            fld_off;
    logic                  is_magic;
    logic [2:0]            lane;
    logic [1:0]            fld_idx;
    logic                  field_done;
    logic [FIELD_BITS-1:0] merged;
    logic                  reach_hdr;
    phase_t                phase_eff;
    logic                  wrap;
    logic [COORD_BITS-1:0] row_inc;
    logic [COORD_BITS-1:0] row_eff;
    logic [COORD_BITS-1:0] col_eff;
    logic [COORD_BITS-1:0] col_inc;

    assign b = word.data_byte;

    // fixed header byte placement
    assign in_fixed = pos_reg < POSITION_BITS'(FIXED_HEADER_END);
    assign pos_lo   = pos_reg[5:0];
    assign fld_off  = pos_lo - 6'd4;
    assign is_magic = pos_lo <= 6'(MAGIC_LAST_POS);
    assign lane     = is_magic ? {1'b0, pos_lo[1:0]} : fld_off[2:0];
    assign fld_idx  = fld_off[4:3];
    assign field_done = is_magic ? (pos_lo == 6'(MAGIC_LAST_POS)) : (lane == 3'd7);

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            merged[8*i +: 8] = (lane == 3'(i)) ? (shifter_reg[8*i +: 8] | b)
                                               : shifter_reg[8*i +: 8];
        end
    end

    // variable-length part
    assign reach_hdr = FIELD_BITS'(pos_reg) >= hdr_len_reg;
    assign phase_eff = (phase_reg != PH_CONTENT && reach_hdr) ? PH_CONTENT : phase_reg;

    // pixel coordinates, saturating
    assign wrap    = frame_width_reg <= FIELD_BITS'(col_reg);
    assign row_inc = (row_reg == '1) ? row_reg : row_reg + COORD_BITS'(1);
    assign row_eff = wrap ? row_inc : row_reg;
    assign col_eff = wrap ? '0 : col_reg;
    assign col_inc = (col_eff == '1) ? col_eff : col_eff + COORD_BITS'(1);

    // phase next state
    always_comb
    begin
        phase_next = phase_reg;
        if (in_fixed)
        begin
            if (pos_lo == 6'(FIXED_HEADER_END - 1))
            begin
                phase_next = PH_CAPTION;
            end
        end
        else
        begin
            unique case (phase_eff)
                PH_CAPTION: phase_next = (b == CHAR_NEWLINE) ? PH_TAGS : PH_CAPTION;
                PH_TAGS:    phase_next = PH_TAGS;
                default:    phase_next = PH_CONTENT;
            endcase
        end
        if (word.last_byte)
        begin
            phase_next = PH_FIXED;
        end
    end

    // datapath and result
    always_comb
    begin
        result           = '0;
        result.kind      = KIND_NONE;
        result.file_end  = word.last_byte;
        shifter_next     = shifter_reg;
        hdr_len_next     = hdr_len_reg;
        frame_width_next = frame_width_reg;
        pix_cnt_next     = pix_cnt_reg;
        red_next         = red_reg;
        green_next       = green_reg;
        row_next         = row_reg;
        col_next         = col_reg;

        if (in_fixed)
        begin
            shifter_next = merged;
            if (field_done)
            begin
                result.field_value = merged;
                shifter_next       = '0;
                if (is_magic)
                begin
                    result.kind = KIND_MAGIC;
                end
                else
                begin
                    unique case (fld_idx)
                        2'd0:
                        begin
                            result.kind  = KIND_HEADER_SIZE;
                            hdr_len_next = merged;
                        end
                        2'd1:
                        begin
                            result.kind = KIND_CONTENT_SIZE;
                        end
                        2'd2:
                        begin
                            result.kind      = KIND_WIDTH;
                            frame_width_next = merged;
                        end
                        default:
                        begin
                            result.kind = KIND_HEIGHT;
                        end
                    endcase
                end
            end
        end
        else if (phase_eff == PH_CAPTION)
        begin
            result.kind        = KIND_CAPTION;
            result.field_value = FIELD_BITS'(b);
            result.piece_end   = (b == CHAR_NEWLINE);
        end
        else if (phase_eff == PH_TAGS)
        begin
            result.kind        = KIND_TAG;
            result.field_value = FIELD_BITS'(b);
            result.piece_end   = (b == CHAR_NUL);
        end
        else
        begin
            case (pix_cnt_reg)
                2'd0:
                begin
                    red_next     = b;
                    green_next   = '0;
                    pix_cnt_next = 2'd1;
                end
                2'd1:
                begin
                    green_next   = b;
                    pix_cnt_next = 2'd2;
                end
                default:
                begin
                    result.kind      = KIND_PIXEL;
                    result.red       = red_reg;
                    result.green     = green_reg;
                    result.blue      = b;
                    result.pix_row   = OUT_COORD_BITS'(row_eff);
                    result.pixel_col = OUT_COORD_BITS'(col_eff);
                    row_next         = row_eff;
                    col_next         = col_inc;
                    pix_cnt_next     = 2'd0;
                    red_next         = '0;
                    green_next       = '0;
                end
            endcase
        end

        // end of file returns to the start
        if (word.last_byte)
        begin
            shifter_next     = '0;
            hdr_len_next     = '0;
            frame_width_next = '0;
            pix_cnt_next     = '0;
            red_next         = '0;
            green_next       = '0;
            row_next         = '0;
            col_next         = '0;
        end
    end

    // byte position, saturating
    always_comb
    begin
        pos_next = (pos_reg == '1) ? pos_reg : pos_reg + POSITION_BITS'(1);
        if (word.last_byte)
        begin
            pos_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            shifter_reg     <= '0;
            hdr_len_reg     <= '0;
            frame_width_reg <= '0;
            phase_reg       <= PH_FIXED;
            pix_cnt_reg     <= '0;
            red_reg         <= '0;
            green_reg       <= '0;
            row_reg         <= '0;
            col_reg         <= '0;
        end
        else if (fire)
        begin
            pos_reg         <= pos_next;
            shifter_reg     <= shifter_next;
            hdr_len_reg     <= hdr_len_next;
            frame_width_reg <= frame_width_next;
            phase_reg       <= phase_next;
            pix_cnt_reg     <= pix_cnt_next;
            red_reg         <= red_next;
            green_reg       <= green_next;
            row_reg         <= row_next;
            col_reg         <= col_next;
        end
    end

endmodule

`default_nettype wire

/* sv/cisp_out_reg.sv */
// result register with valid/stall handshake
`default_nettype none

module cisp_out_reg
    import cisp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load,
    input  wire result_t result,
    output logic         ready,
    output logic         out_valid,
    input  wire logic    out_stall,
    output result_t      out_word
);

    logic    valid_reg;
    logic    valid_next;
    result_t word_reg;

    // room when empty or the word leaves this cycle
    assign ready = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= result;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

`default_nettype wire

/* sv/ciff_image_stream_parser.sv */
// top level of the image stream parser
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid, in_stall   | data_byte, last_byte
//   out     | output    | out_valid, out_stall | kind, field_value, red, green, blue,
//           |           |                      | pix_row, pixel_col, piece_end, file_end
//
// one result word per input word; a new byte is taken every cycle while the output is not stalled
// a byte passes through the input register, then is decoded into the result register
// the decode updates all parser state in the cycle a byte moves to the result register
// rst_n clears the parser to the start of a file; a byte with last_byte does the same
// a stall on the output holds both registers and backs up to in_stall in the same cycle
`default_nettype none

module ciff_image_stream_parser
    import cisp_pkg::*;
#(
    parameter int POSITION_BITS = 32,
    parameter int COORD_BITS    = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [3:0]       kind,
    output logic [63:0]      field_value,
    output logic [7:0]       red,
    output logic [7:0]       green,
    output logic [7:0]       blue,
    output logic [15:0]      pix_row,
    output logic [15:0]      pixel_col,
    output logic             piece_end,
    output logic             file_end
);

    in_word_t in_word;
    in_word_t held_word;
    logic     advance;
    logic     down_ready;
    result_t  result;
    result_t  out_word;

    assign in_word.data_byte = data_byte;
    assign in_word.last_byte = last_byte;

    // input stage
    cisp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_word    (in_word),
        .down_ready (down_ready),
        .advance    (advance),
        .held_word  (held_word)
    );

    // parser
    cisp_core #(
        .POSITION_BITS (POSITION_BITS),
        .COORD_BITS    (COORD_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .word   (held_word),
        .result (result)
    );

    // result stage
    cisp_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .result    (result),
        .ready     (down_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    assign kind        = out_word.kind;
    assign field_value = out_word.field_value;
    assign red         = out_word.red;
    assign green       = out_word.green;
    assign blue        = out_word.blue;
    assign pix_row     = out_word.pix_row;
    assign pixel_col   = out_word.pixel_col;
    assign piece_end   = out_word.piece_end;
    assign file_end    = out_word.file_end;

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// self-checking bench for the image stream parser: directed words, random files, long files
`timescale 1ns / 1ps

module tb_top;
    import cisp_pkg::*;

    // one row of the directed table
    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         typed;
        result_t    res;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [3:0]  kind;
    logic [63:0] field_value;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] pix_row;
    logic [15:0] pixel_col;
    logic        piece_end;
    logic        file_end;

    // parser state mirrored by the predictor
    logic [31:0] pos_q;
    logic [63:0] shift_q;
    logic [63:0] hdr_len_q;
    logic [63:0] width_q;
    phase_t      phase_q;
    logic [1:0]  pix_cnt_q;
    logic [15:0] rg_q;
    logic [15:0] row_q;
    logic [15:0] col_q;

    result_t     pending_results[$];
    logic [7:0]  image_bytes[$];
    dir_row_t    dir_tab[$];

    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    int          err_count     = 0;
    int          words_sent    = 0;
    int          results_seen  = 0;
    int          pixels_seen   = 0;
    int          files_sent    = 0;

    ciff_image_stream_parser DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .last_byte   (last_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .field_value (field_value),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .pix_row     (pix_row),
        .pixel_col   (pixel_col),
        .piece_end   (piece_end),
        .file_end    (file_end)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // run limit
    initial
    begin
        #30_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // receiver stall
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic report_mismatch(input string msg);
        err_count++;
        $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    function automatic logic [15:0] coord_step(input logic [15:0] c);
        return (c == 16'hFFFF) ? c : c + 16'd1;
    endfunction

    function automatic void clear_parser();
        pos_q     = '0;
        shift_q   = '0;
        hdr_len_q = '0;
        width_q   = '0;
        phase_q   = PH_FIXED;
        pix_cnt_q = '0;
        rg_q      = '0;
        row_q     = '0;
        col_q     = '0;
    endfunction

    function automatic result_t field_res(input kind_t k, input logic [63:0] v, input logic fe);
        result_t r;
        r             = '0;
        r.kind        = k;
        r.field_value = v;
        r.file_end    = fe;
        return r;
    endfunction

    // appends one row to the directed table
    function automatic void add_row(input logic [7:0] d, input logic l, input bit t,
                                    input result_t res);
        dir_row_t row;
        row.data  = d;
        row.last  = l;
        row.typed = t;
        row.res   = res;
        dir_tab.insert(dir_tab.size(), row);
    endfunction

    // appends one byte to the file being built
    function automatic void add_byte(input logic [7:0] v);
        image_bytes.insert(image_bytes.size(), v);
    endfunction

    // predicts the result word of one byte and advances the mirrored state
    function automatic result_t parse_byte(input logic [7:0] b, input logic l);
        result_t r;
        int      slot;
        int      idx;
        r      = '0;
        r.kind = KIND_NONE;
        if (pos_q < FIXED_HEADER_END)
        begin
            if (pos_q <= MAGIC_LAST_POS)
            begin
                shift_q = shift_q | (64'(b) << (8 * pos_q));
                if (pos_q == MAGIC_LAST_POS)
                begin
                    r.kind        = KIND_MAGIC;
                    r.field_value = shift_q;
                    shift_q       = '0;
                end
            end
            else
            begin
                slot    = (int'(pos_q) - 4) & 7;
                idx     = (int'(pos_q) - 4) >> 3;
                shift_q = shift_q | (64'(b) << (8 * slot));
                if (slot == 7)
                begin
                    case (idx)
                        0:
                        begin
                            r.kind    = KIND_HEADER_SIZE;
                            hdr_len_q = shift_q;
                        end
                        1:       r.kind = KIND_CONTENT_SIZE;
                        2:
                        begin
                            r.kind  = KIND_WIDTH;
                            width_q = shift_q;
                        end
                        default: r.kind = KIND_HEIGHT;
                    endcase
                    r.field_value = shift_q;
                    shift_q       = '0;
                end
            end
            if (pos_q == FIXED_HEADER_END - 1)
                phase_q = PH_CAPTION;
        end
        else
        begin
            if (phase_q != PH_CONTENT && 64'(pos_q) >= hdr_len_q)
                phase_q = PH_CONTENT;
            case (phase_q)
                PH_CAPTION:
                begin
                    r.kind        = KIND_CAPTION;
                    r.field_value = 64'(b);
                    if (b == CHAR_NEWLINE)
                    begin
                        r.piece_end = 1'b1;
                        phase_q     = PH_TAGS;
                    end
                end
                PH_TAGS:
                begin
                    r.kind        = KIND_TAG;
                    r.field_value = 64'(b);
                    r.piece_end   = (b == CHAR_NUL);
                end
                default:
                begin
                    phase_q = PH_CONTENT;
                    if (pix_cnt_q == 2'd0)
                    begin
                        rg_q      = {8'h00, b};
                        pix_cnt_q = 2'd1;
                    end
                    else if (pix_cnt_q == 2'd1)
                    begin
                        rg_q[15:8] = b;
                        pix_cnt_q  = 2'd2;
                    end
                    else
                    begin
                        // column wraps once it reaches the width
                        if (width_q <= 64'(col_q))
                        begin
                            row_q = coord_step(row_q);
                            col_q = '0;
                        end
                        r.kind      = KIND_PIXEL;
                        r.red       = rg_q[7:0];
                        r.green     = rg_q[15:8];
                        r.blue      = b;
                        r.pix_row   = row_q;
                        r.pixel_col = col_q;
                        col_q       = coord_step(col_q);
                        pix_cnt_q   = 2'd0;
                        rg_q        = '0;
                    end
                end
            endcase
        end
        if (pos_q != '1)
            pos_q = pos_q + 32'd1;
        r.file_end = l;
        if (l)
            clear_parser();
        return r;
    endfunction

    // drives one word, waits for it to be taken and records its expected result
    task automatic send_word(input logic [7:0] b, input logic l,
                             input bit typed, input result_t typed_res);
        result_t pred;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= l;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pred = parse_byte(b, l);
        pending_results.insert(pending_results.size(), typed ? typed_res : pred);
        words_sent++;
        @(negedge clk);
    endtask

    // magic and the four little-endian fields
    task automatic push_header(input logic [63:0] hsize, input logic [63:0] csize,
                               input logic [63:0] wid, input logic [63:0] hgt);
        logic [63:0] fields [4];
        fields = '{hsize, csize, wid, hgt};
        for (int i = 0; i < 4; i++)
            add_byte(8'($urandom_range(255)));
        for (int f = 0; f < 4; f++)
            for (int k = 0; k < 8; k++)
                add_byte(fields[f][8*k +: 8]);
    endtask

    // one random file: mostly well formed, some cut short, some pure noise
    task automatic send_image();
        logic [63:0] hsize;
        logic [63:0] wid;
        int          r;
        int          sel;
        int          nbody;
        int          ncontent;
        int          keep;
        logic [7:0]  b;
        image_bytes.delete();
        r = $urandom_range(99);
        if (r < 10)
        begin
            repeat ($urandom_range(1, 60))
                add_byte(8'($urandom_range(255)));
        end
        else
        begin
            sel = $urandom_range(99);
            if (sel < 20)
                hsize = 64'($urandom_range(FIXED_HEADER_END));
            else if (sel < 75)
                hsize = 64'(FIXED_HEADER_END + $urandom_range(1, 24));
            else if (sel < 85)
                hsize = '1;
            else
                hsize = {$urandom, $urandom};
            sel = $urandom_range(99);
            if (sel < 15)
                wid = '0;
            else if (sel < 65)
                wid = 64'($urandom_range(1, 5));
            else if (sel < 85)
                wid = 64'($urandom_range(6, 20));
            else
                wid = {$urandom, $urandom};
            push_header(hsize, {$urandom, $urandom}, wid, {$urandom, $urandom});
            // caption and tag bytes, with newlines and zeros sprinkled in
            if (hsize > 64'(FIXED_HEADER_END) && hsize <= 64'd60)
                nbody = int'(hsize) - FIXED_HEADER_END;
            else if (hsize > 64'd60)
                nbody = $urandom_range(4, 30);
            else
                nbody = 0;
            for (int i = 0; i < nbody; i++)
            begin
                sel = $urandom_range(99);
                if (sel < 12)
                    b = CHAR_NEWLINE;
                else if (sel < 30)
                    b = CHAR_NUL;
                else
                    b = 8'($urandom_range(255));
                add_byte(b);
            end
            // content, often not a whole number of pixels
            ncontent = (hsize <= 64'd60) ? $urandom_range(0, 30) : 0;
            for (int i = 0; i < ncontent; i++)
                add_byte(8'($urandom_range(255)));
            if (r < 25)
            begin
                keep = $urandom_range(1, image_bytes.size());
                while (image_bytes.size() > keep)
                    void'(image_bytes.pop_back());
            end
        end
        for (int i = 0; i < image_bytes.size(); i++)
            send_word(image_bytes[i], i == image_bytes.size() - 1, 1'b0, '0);
        files_sent++;
    endtask

    // longer file with many pixels in one frame
    task automatic send_long_image(input logic [63:0] wid);
        int nbytes;
        image_bytes.delete();
        push_header(64'(FIXED_HEADER_END), {$urandom, $urandom}, wid, {$urandom, $urandom});
        foreach (image_bytes[i])
            send_word(image_bytes[i], 1'b0, 1'b0, '0);
        // one spare byte leaves a partial pixel at the end
        nbytes = 3 * 40 + 1;
        for (int i = 0; i < nbytes; i++)
            send_word(8'($urandom_range(255)), i == nbytes - 1, 1'b0, '0);
        files_sent++;
    endtask

    // result checker
    always @(posedge clk)
    begin : result_check
        result_t got;
        result_t exp;
        string   bad;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            got.kind        = kind_t'(kind);
            got.field_value = field_value;
            got.red         = red;
            got.green       = green;
            got.blue        = blue;
            got.pix_row     = pix_row;
            got.pixel_col   = pixel_col;
            got.piece_end   = piece_end;
            got.file_end    = file_end;
            results_seen++;
            if (got.kind == KIND_PIXEL)
                pixels_seen++;
            if (pending_results.size() == 0)
                report_mismatch($sformatf("result kind %0d with nothing expected", kind));
            else
            begin
                exp = pending_results.pop_front();
                bad = "";
                if (got.kind !== exp.kind)               bad = {bad, " kind"};
                if (got.field_value !== exp.field_value) bad = {bad, " field_value"};
                if (got.red !== exp.red)                 bad = {bad, " red"};
                if (got.green !== exp.green)             bad = {bad, " green"};
                if (got.blue !== exp.blue)               bad = {bad, " blue"};
                if (got.pix_row !== exp.pix_row)         bad = {bad, " pix_row"};
                if (got.pixel_col !== exp.pixel_col)     bad = {bad, " pixel_col"};
                if (got.piece_end !== exp.piece_end)     bad = {bad, " piece_end"};
                if (got.file_end !== exp.file_end)       bad = {bad, " file_end"};
                if (bad != "")
                    report_mismatch($sformatf(
                        "word %0d%s: got k%0d v%h rgb %h%h%h @%0d,%0d pe%b fe%b, exp k%0d v%h",
                        results_seen - 1, bad, got.kind, got.field_value, got.red, got.green,
                        got.blue, got.pix_row, got.pixel_col, got.piece_end, got.file_end,
                        exp.kind, exp.field_value));
            end
        end
    end

    // stimulus
    initial
    begin : stimulus
        int random_target;
        in_valid  = 1'b0;
        data_byte = 8'h00;
        last_byte = 1'b0;
        rst_n     = 1'b0;
        clear_parser();

        // short file of zeros, cut after the magic
        add_row(8'h00, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b1, field_res(KIND_MAGIC, 64'h0, 1'b0));
        add_row(8'h00, 1'b1, 1'b1, field_res(KIND_NONE, 64'h0, 1'b1));
        // all ones magic, file ends on its last byte
        add_row(8'hFF, 1'b0, 1'b0, '0);
        add_row(8'hFF, 1'b0, 1'b0, '0);
        add_row(8'hFF, 1'b0, 1'b0, '0);
        add_row(8'hFF, 1'b1, 1'b1, field_res(KIND_MAGIC, 64'hFFFF_FFFF, 1'b1));
        // one byte file
        add_row(8'h5A, 1'b1, 1'b1, field_res(KIND_NONE, 64'h0, 1'b1));
        // magic byte order, then a header size field of 36
        add_row(8'h01, 1'b0, 1'b0, '0);
        add_row(8'h02, 1'b0, 1'b0, '0);
        add_row(8'h03, 1'b0, 1'b0, '0);
        add_row(8'h80, 1'b0, 1'b1, field_res(KIND_MAGIC, 64'h8003_0201, 1'b0));
        add_row(8'h24, 1'b0, 1'b0, '0);
        for (int i = 0; i < 6; i++)
            add_row(8'h00, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b1, field_res(KIND_HEADER_SIZE, 64'd36, 1'b0));
        add_row(8'hA5, 1'b1, 1'b1, field_res(KIND_NONE, 64'h0, 1'b1));

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // directed words
        foreach (dir_tab[i])
            send_word(dir_tab[i].data, dir_tab[i].last, dir_tab[i].typed, dir_tab[i].res);

        // random files in four idling phases
        random_target = words_sent + 720;
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 65;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 65;
                end
                default:
                begin
                    send_idle_pct = 6;
                    stall_pct     = 6;
                end
            endcase
            while (words_sent < random_target - (3 - ph) * 720 / 4)
                send_image();
        end

        // a new row for every pixel with width zero, then one long row with a huge width
        send_idle_pct = 0;
        stall_pct     = 0;
        send_long_image('0);
        send_long_image('1);
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("covered %0d words in %0d files (%0d directed), %0d results, %0d pixels",
                 words_sent, files_sent, dir_tab.size(), results_seen, pixels_seen);
        $display("idling phases: none, sender 65%%, receiver 65%%, both 6%%; zero and huge widths");
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
